### design/svp_pkg.sv
// ----------------------------------------------------------------------------
// svp_pkg
// Shared types and constants for the serial angle to servo pulse unit.
// ----------------------------------------------------------------------------
package svp_pkg;

    localparam int ANGLE_W = 10;
    localparam int PULSE_W = 16;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 16'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 16'd2500;
    localparam logic [PULSE_W-1:0] PULSE_RESET     = 16'd1500;

    localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 10'd180;
    localparam logic [ANGLE_W-1:0] VALUE_CAP   = 10'd1023;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;

    // Width of |max-min| * angle, with angle at most 180.
    localparam int PROD_W = 24;
    // Quotient by 180 is taken as (n >> 2) / 45, done as a multiply by
    // ceil(2^28 / 45) and a shift; exact for every 22-bit dividend.
    localparam int QUOT_IN_W  = PROD_W - 2;
    localparam int RECIP_SH   = 28;
    localparam int RECIP_W    = 23;
    localparam logic [RECIP_W-1:0] RECIP_45 = 23'd5965233;
    localparam logic [PROD_W-1:0]  ROUND_UP = 24'd179;

    // Line closing event handed from the parser to the pulse pipeline.
    typedef struct packed {
        logic               close;
        logic [ANGLE_W-1:0] angle;
    } line_evt_t;

endpackage

### design/serial_angle_to_servo_pulse_unit.sv
// ----------------------------------------------------------------------------
// serial_angle_to_servo_pulse_unit
// Turns received text lines holding an angle into a servo pulse width.
// ----------------------------------------------------------------------------
// The unit takes one received byte in every cycle while in_ready is high. A
// CR or LF that closes a non-empty line produces one result word: as the byte
// is taken, the line's value enters a capture stage; the product stage then
// forms |max-min| * angle, and the output register is loaded last, where the
// floor division by 180 (a reciprocal multiply) and the pulse update happen.
// The three stages advance independently, so bytes keep flowing while a result
// waits on the output; in_ready drops only when all three stages hold words
// and the output is stalled. Configuration writes are always taken (cfg_ready
// is high) and are meant to happen only while no line result is in flight.
module serial_angle_to_servo_pulse_unit
    import svp_pkg::*;
#(
    parameter int BUFFER_SIZE = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PULSE_W-1:0]   cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 command_valid,
    output logic [ANGLE_W-1:0]   angle,
    output logic [PULSE_W-1:0]   pulse_width
);

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;

    line_evt_t evt;

    // Stage A: captured line value.
    logic               a_valid_reg;
    logic               a_ok_reg;
    logic               a_neg_reg;
    logic [ANGLE_W-1:0] a_angle_reg;
    logic [PULSE_W-1:0] a_dmag_reg;

    // Stage B: product.
    logic               b_valid_reg;
    logic               b_ok_reg;
    logic               b_neg_reg;
    logic [ANGLE_W-1:0] b_angle_reg;
    logic [PROD_W-1:0]  b_prod_reg;

    // Stage C: output register.
    logic               c_valid_reg;
    logic               c_ok_reg;
    logic [ANGLE_W-1:0] c_angle_reg;
    logic [PULSE_W-1:0] c_pulse_reg;

    logic c_free, b_free, a_free;
    logic load_a, load_b, load_c;

    logic [PULSE_W-1:0]           dmag;
    logic                         dneg;
    logic [PROD_W-1:0]            dividend;
    logic [QUOT_IN_W+RECIP_W-1:0] recip_prod;
    logic [PULSE_W-1:0]           quot;

    assign cfg_ready = 1'b1;

    assign c_free = !c_valid_reg || out_ready;
    assign b_free = !b_valid_reg || c_free;
    assign a_free = !a_valid_reg || b_free;

    assign in_ready = a_free;
    assign load_a   = evt.close;
    assign load_b   = a_valid_reg && b_free;
    assign load_c   = b_valid_reg && c_free;

    svp_line_parser #(
        .BUFFER_SIZE (BUFFER_SIZE)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_valid && in_ready),
        .rx_byte (rx_byte),
        .evt     (evt)
    );

    always_comb
    begin
        dneg = max_pulse_reg < min_pulse_reg;
        dmag = dneg ? (min_pulse_reg - max_pulse_reg) : (max_pulse_reg - min_pulse_reg);

        // A negative difference rounds toward minus infinity: -ceil(|p| / 180).
        dividend   = b_neg_reg ? (b_prod_reg + ROUND_UP) : b_prod_reg;
        recip_prod = (QUOT_IN_W+RECIP_W)'(dividend[PROD_W-1:2])
                   * (QUOT_IN_W+RECIP_W)'(RECIP_45);
        quot       = recip_prod[RECIP_SH +: PULSE_W];

        pulse_next = pulse_reg;
        if (b_ok_reg)
        begin
            pulse_next = b_neg_reg ? (min_pulse_reg - quot) : (min_pulse_reg + quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg <= MIN_PULSE_RESET;
            max_pulse_reg <= MAX_PULSE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_MIN_PULSE)
            begin
                min_pulse_reg <= cfg_data;
            end
            else if (cfg_index == CFG_MAX_PULSE)
            begin
                max_pulse_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            pulse_reg   <= PULSE_RESET;
        end
        else
        begin
            if (load_a)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (load_b)
            begin
                a_valid_reg <= 1'b0;
            end

            if (load_b)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (load_c)
            begin
                b_valid_reg <= 1'b0;
            end

            if (load_c)
            begin
                c_valid_reg <= 1'b1;
                pulse_reg   <= pulse_next;
            end
            else if (out_ready)
            begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_angle_reg <= evt.angle;
            a_ok_reg    <= evt.angle <= ANGLE_LIMIT;
            a_neg_reg   <= dneg;
            a_dmag_reg  <= dmag;
        end
        if (load_b)
        begin
            b_angle_reg <= a_angle_reg;
            b_ok_reg    <= a_ok_reg;
            b_neg_reg   <= a_neg_reg;
            b_prod_reg  <= PROD_W'(a_dmag_reg) * PROD_W'(a_angle_reg[7:0]);
        end
        if (load_c)
        begin
            c_angle_reg <= b_angle_reg;
            c_ok_reg    <= b_ok_reg;
            c_pulse_reg <= pulse_next;
        end
    end

    assign out_valid     = c_valid_reg;
    assign command_valid = c_ok_reg;
    assign angle         = c_angle_reg;
    assign pulse_width   = c_pulse_reg;

    property p_reject_keeps_pulse;
        @(posedge clk) disable iff (!rst_n)
        (load_c && !b_ok_reg) |=> (pulse_reg == $past(pulse_reg));
    endproperty
    a_reject_keeps_pulse: assert property (p_reject_keeps_pulse)
        else $error("rejected command changed the pulse width");

    property p_out_matches_pulse;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (pulse_width == pulse_reg);
    endproperty
    a_out_matches_pulse: assert property (p_out_matches_pulse)
        else $error("shown pulse width differs from the pulse register");

    property p_valid_angle_in_range;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && command_valid) |-> (angle <= ANGLE_LIMIT);
    endproperty
    a_valid_angle_in_range: assert property (p_valid_angle_in_range)
        else $error("accepted command with angle above the limit");

    property p_stall_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (a_valid_reg && b_valid_reg && c_valid_reg && !out_ready);
    endproperty
    a_stall_only_when_full: assert property (p_stall_only_when_full)
        else $error("input stalled while the pipeline had room");

endmodule

### design/svp_line_parser.sv
// ----------------------------------------------------------------------------
// svp_line_parser
// Collects received bytes into lines and builds the leading decimal value.
// ----------------------------------------------------------------------------
module svp_line_parser
    import svp_pkg::*;
#(
    parameter int BUFFER_SIZE = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output line_evt_t         evt
);

    localparam int CNT_W = (BUFFER_SIZE > 2) ? $clog2(BUFFER_SIZE) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_SIZE - 1);

    logic [CNT_W-1:0]   char_count_reg, char_count_next;
    logic [ANGLE_W-1:0] digit_value_reg, digit_value_next;
    logic               digits_ended_reg, digits_ended_next;

    logic               is_eol;
    logic               is_digit;
    logic [13:0]        accum;

    always_comb
    begin
        is_eol   = rx_byte inside {CHAR_CR, CHAR_LF};
        is_digit = rx_byte inside {[CHAR_0:CHAR_9]};
        accum    = 14'(digit_value_reg) * 14'd10 + 14'(rx_byte - CHAR_0);

        char_count_next   = char_count_reg;
        digit_value_next  = digit_value_reg;
        digits_ended_next = digits_ended_reg;

        if (accept)
        begin
            if (is_eol)
            begin
                if (char_count_reg != '0)
                begin
                    char_count_next   = '0;
                    digit_value_next  = '0;
                    digits_ended_next = 1'b0;
                end
            end
            else if (char_count_reg < CNT_MAX)
            begin
                char_count_next = char_count_reg + 1'b1;
                if (!digits_ended_reg)
                begin
                    if (is_digit)
                    begin
                        digit_value_next = (accum > 14'(VALUE_CAP)) ? VALUE_CAP
                                                                    : accum[ANGLE_W-1:0];
                    end
                    else
                    begin
                        digits_ended_next = 1'b1;
                    end
                end
            end
        end

        evt.close = accept && is_eol && (char_count_reg != '0);
        evt.angle = digit_value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            digit_value_reg  <= '0;
            digits_ended_reg <= 1'b0;
        end
        else
        begin
            char_count_reg   <= char_count_next;
            digit_value_reg  <= digit_value_next;
            digits_ended_reg <= digits_ended_next;
        end
    end

    property p_count_bounded;
        @(posedge clk) disable iff (!rst_n)
        char_count_reg <= CNT_MAX;
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("line character count beyond buffer");

    property p_close_clears;
        @(posedge clk) disable iff (!rst_n)
        evt.close |=> (char_count_reg == '0) && (digit_value_reg == '0) && !digits_ended_reg;
    endproperty
    a_close_clears: assert property (p_close_clears)
        else $error("line state not cleared after closing a line");

    property p_no_growth_when_ended;
        @(posedge clk) disable iff (!rst_n)
        (digits_ended_reg && !evt.close) |=> $stable(digit_value_reg);
    endproperty
    a_no_growth_when_ended: assert property (p_no_growth_when_ended)
        else $error("digit value changed after the digit run ended");

endmodule
